@@ sv/wrsl_pkg.sv @@
package wrsl_pkg;

	// Operation selector carried in the slave-side tuser.
	typedef enum logic [1:0] {
		FN_BIND  = 2'd0,
		FN_STOP  = 2'd1,
		FN_ACK   = 2'd2,
		FN_QUERY = 2'd3
	} func_t;

	// Result status carried in the master-side tuser.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_STALE     = 3'd2,
		ST_CONFLICT  = 3'd3,
		ST_ACKED     = 3'd4,
		ST_NOT_READY = 3'd5
	} status_t;

	// Lifecycle phase, one-hot.
	typedef enum logic [3:0] {
		PH_UNBOUND  = 4'b0001,
		PH_BOUND    = 4'b0010,
		PH_PENDING  = 4'b0100,
		PH_QUIESCED = 4'b1000
	} phase_t;

	// Phase codes as they appear in phase_now.
	localparam logic [1:0] PHC_UNBOUND  = 2'd0;
	localparam logic [1:0] PHC_BOUND    = 2'd1;
	localparam logic [1:0] PHC_PENDING  = 2'd2;
	localparam logic [1:0] PHC_QUIESCED = 2'd3;

	// Configuration register indexes.
	localparam int unsigned REG_WORKER_KIND = 0;

	localparam int unsigned STREAM_IN_BYTES  = 17;
	localparam int unsigned STREAM_OUT_BYTES = 33;

	typedef struct packed {
		func_t       func;
		logic [31:0] boot_key;
		logic [31:0] run_key;
		logic [31:0] generation_key;
		logic [31:0] stop_tag;
		logic        resources_freed;
		logic        gate_open;
	} item_t;

	// Lifecycle state with keys widened to 32 bits.
	typedef struct packed {
		phase_t      phase;
		logic [31:0] boot;
		logic [31:0] run;
		logic [31:0] generation;
		logic [31:0] stop;
		logic [31:0] binds;
		logic [31:0] stops;
		logic [31:0] acks;
		logic [31:0] rejects;
	} lc_state_t;

	typedef struct packed {
		status_t     status;
		logic [1:0]  phase_now;
		logic [31:0] bound_boot;
		logic [31:0] bound_run;
		logic [31:0] bound_generation;
		logic [31:0] latched_stop;
		logic        mutation_allowed;
		logic        new_work_allowed;
		logic [31:0] binds_seen;
		logic [31:0] stops_latched;
		logic [31:0] acks_built;
		logic [31:0] rejects_seen;
	} result_t;

	function automatic logic [1:0] phase_code(phase_t ph);
		logic [1:0] code;
		unique case (ph)
			PH_UNBOUND:  code = PHC_UNBOUND;
			PH_BOUND:    code = PHC_BOUND;
			PH_PENDING:  code = PHC_PENDING;
			PH_QUIESCED: code = PHC_QUIESCED;
			default:     code = PHC_UNBOUND;
		endcase
		return code;
	endfunction

	// Increment that holds at the all-ones value.
	function automatic logic [31:0] sat_inc(logic [31:0] c);
		return (c == '1) ? c : c + 32'd1;
	endfunction

endpackage

@@ sv/wrsl_cfg.sv @@
module wrsl_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import wrsl_pkg::*;

	localparam logic [2:0] ADDR_WORKER_KIND = 3'(REG_WORKER_KIND * 4);

	logic worker_kind_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// The worker kind is kept for software; it does not change the lifecycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			worker_kind_q <= 1'b0;
		end else if (wr_en && paddr == ADDR_WORKER_KIND) begin
			worker_kind_q <= pwdata[0];
		end
	end

	// Read mux.
	always_comb begin
		prdata = '0;
		if (paddr == ADDR_WORKER_KIND) begin
			prdata = {31'd0, worker_kind_q};
		end
	end

endmodule

@@ sv/wrsl_step.sv @@
module wrsl_step #(
	parameter int unsigned KEY_W = 32
) (
	input  wrsl_pkg::lc_state_t st,
	input  wrsl_pkg::item_t     item,
	output wrsl_pkg::lc_state_t nxt,
	output wrsl_pkg::result_t   res
);
	import wrsl_pkg::*;

	localparam logic [31:0] KEY_MASK = 32'((64'd1 << KEY_W) - 64'd1);

	logic [31:0] b_key;
	logic [31:0] r_key;
	logic [31:0] g_key;
	logic        key_eq;
	logic        reject;
	status_t     status;

	assign b_key  = item.boot_key & KEY_MASK;
	assign r_key  = item.run_key & KEY_MASK;
	assign g_key  = item.generation_key & KEY_MASK;
	assign key_eq = (b_key == st.boot) && (r_key == st.run) && (g_key == st.generation);

	// Decide the operation outcome from the current phase and the item.
	always_comb begin
		nxt    = st;
		reject = 1'b0;
		status = ST_OK;
		unique case (item.func)
			FN_BIND: begin
				priority if (st.phase == PH_BOUND) begin
					if (!key_eq) begin
						reject = 1'b1;
						status = ST_INVALID;
					end
				end else if (st.phase == PH_PENDING) begin
					reject = 1'b1;
					status = ST_INVALID;
				end else if (st.phase == PH_QUIESCED && key_eq) begin
					reject = 1'b1;
					status = ST_STALE;
				end else begin
					nxt.boot       = b_key;
					nxt.run        = r_key;
					nxt.generation = g_key;
					nxt.stop       = '0;
					nxt.phase      = PH_BOUND;
					nxt.binds      = sat_inc(st.binds);
				end
			end
			FN_STOP: begin
				priority if (st.phase == PH_UNBOUND) begin
					reject = 1'b1;
					status = ST_INVALID;
				end else if (!key_eq) begin
					reject = 1'b1;
					status = ST_STALE;
				end else if (st.phase == PH_QUIESCED) begin
					if (st.stop == item.stop_tag) begin
						status = ST_ACKED;
					end else begin
						reject = 1'b1;
						status = ST_INVALID;
					end
				end else if (st.phase == PH_PENDING) begin
					if (st.stop != item.stop_tag) begin
						reject = 1'b1;
						status = ST_CONFLICT;
					end
				end else begin
					nxt.stop  = item.stop_tag;
					nxt.phase = PH_PENDING;
					nxt.stops = sat_inc(st.stops);
				end
			end
			FN_ACK: begin
				priority if (st.phase == PH_QUIESCED) begin
					status = ST_ACKED;
				end else if (st.phase != PH_PENDING) begin
					reject = 1'b1;
					status = ST_INVALID;
				end else if (!item.resources_freed) begin
					status = ST_NOT_READY;
				end else begin
					nxt.phase = PH_QUIESCED;
					nxt.acks  = sat_inc(st.acks);
				end
			end
			FN_QUERY: begin
				status = ST_OK;
			end
			default: begin
				status = ST_OK;
			end
		endcase
		if (reject) begin
			nxt.rejects = sat_inc(st.rejects);
		end
	end

	// Snapshot after the step plus the gating flags.
	always_comb begin
		res.status           = status;
		res.phase_now        = phase_code(nxt.phase);
		res.bound_boot       = nxt.boot;
		res.bound_run        = nxt.run;
		res.bound_generation = nxt.generation;
		res.latched_stop     = nxt.stop;
		res.mutation_allowed = (nxt.phase == PH_BOUND) || (nxt.phase == PH_PENDING);
		res.new_work_allowed = (nxt.phase == PH_BOUND) && item.gate_open;
		res.binds_seen       = nxt.binds;
		res.stops_latched    = nxt.stops;
		res.acks_built       = nxt.acks;
		res.rejects_seen     = nxt.rejects;
	end

endmodule

@@ sv/worker_run_stop_lifecycle.sv @@
// Lifecycle guard for one worker: bind a run, request a stop, build the
// quiesced acknowledgement, or just query the snapshot.
// Input words arrive on the s_ stream: s_tuser holds the operation, s_tdata
// the run key, stop tag and the two status flags. Each input word gives
// exactly one result word on the m_ stream: m_tuser holds the status,
// m_tdata the phase, stored key, stop id, gating flags and four counters
// that saturate at all ones.
// After acceptance the word is held in the input register, then the phase
// update and counter increments run in a single pass and load the result
// register, which drives m_tvalid. One word is taken every cycle while the
// receiver does not stall; the state update of one word is visible to the
// next word without a bubble.
// When the receiver stalls, the result register holds its word, the input
// register takes one more word, and then s_tready drops until m_tready
// returns. Reset clears the phase to unbound, the key, stop id and counters
// to zero, and empties both registers. The APB port holds the worker kind
// register at address 0; it is kept for software and bit 0 reads back as written.
module worker_run_stop_lifecycle #(
	parameter int unsigned KEY_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration port.
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// Input stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	// boot_key[31:0], run_key[63:32], generation_key[95:64], stop_tag[127:96],
	// resources_freed[128], gate_open[129], zero fill up to 135
	input  logic [wrsl_pkg::STREAM_IN_BYTES*8-1:0]  s_tdata,
	// func[1:0]
	input  logic [1:0]   s_tuser,
	// Result stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	// phase_now[1:0], bound_boot[33:2], bound_run[65:34], bound_generation[97:66],
	// latched_stop[129:98], mutation_allowed[130], new_work_allowed[131],
	// binds_seen[163:132], stops_latched[195:164], acks_built[227:196],
	// rejects_seen[259:228], zero fill up to 263
	output logic [wrsl_pkg::STREAM_OUT_BYTES*8-1:0] m_tdata,
	// status[2:0]
	output logic [2:0]   m_tuser
);
	import wrsl_pkg::*;

	// Keys are taken from 32-bit fields, so at most 32 bits are stored.
	localparam int unsigned KW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;

	item_t       item_s1;
	logic        valid_s1;
	phase_t      phase_q;
	logic [KW-1:0] boot_q;
	logic [KW-1:0] run_q;
	logic [KW-1:0] gen_q;
	logic [31:0] stop_q;
	logic [31:0] binds_q;
	logic [31:0] stops_q;
	logic [31:0] acks_q;
	logic [31:0] rejects_q;
	result_t     res_q;
	logic        m_valid_q;

	lc_state_t   st;
	lc_state_t   nxt;
	result_t     res;
	logic        out_free;
	logic        adv;
	item_t       in_item;

	wrsl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Handshake: the result register frees when empty or being taken.
	assign out_free = !m_valid_q || m_tready;
	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Unpack the input word.
	always_comb begin
		in_item.func            = func_t'(s_tuser);
		in_item.boot_key        = s_tdata[31:0];
		in_item.run_key         = s_tdata[63:32];
		in_item.generation_key  = s_tdata[95:64];
		in_item.stop_tag        = s_tdata[127:96];
		in_item.resources_freed = s_tdata[128];
		in_item.gate_open       = s_tdata[129];
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= in_item;
		end
	end

	// Current state, keys widened for the compare logic.
	always_comb begin
		st.phase      = phase_q;
		st.boot       = 32'(boot_q);
		st.run        = 32'(run_q);
		st.generation = 32'(gen_q);
		st.stop       = stop_q;
		st.binds      = binds_q;
		st.stops      = stops_q;
		st.acks       = acks_q;
		st.rejects    = rejects_q;
	end

	wrsl_step #(
		.KEY_W (KW)
	) u_step (
		.st   (st),
		.item (item_s1),
		.nxt  (nxt),
		.res  (res)
	);

	// Lifecycle state advances as the word moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_UNBOUND;
			boot_q    <= '0;
			run_q     <= '0;
			gen_q     <= '0;
			stop_q    <= '0;
			binds_q   <= '0;
			stops_q   <= '0;
			acks_q    <= '0;
			rejects_q <= '0;
		end else if (adv) begin
			phase_q   <= nxt.phase;
			boot_q    <= nxt.boot[KW-1:0];
			run_q     <= nxt.run[KW-1:0];
			gen_q     <= nxt.generation[KW-1:0];
			stop_q    <= nxt.stop;
			binds_q   <= nxt.binds;
			stops_q   <= nxt.stops;
			acks_q    <= nxt.acks;
			rejects_q <= nxt.rejects;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	// Pack the result word.
	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {4'd0,
		res_q.rejects_seen,
		res_q.acks_built,
		res_q.stops_latched,
		res_q.binds_seen,
		res_q.new_work_allowed,
		res_q.mutation_allowed,
		res_q.latched_stop,
		res_q.bound_generation,
		res_q.bound_run,
		res_q.bound_boot,
		res_q.phase_now};

endmodule

@@ tb/worker_run_stop_lifecycle_tb.sv @@
module worker_run_stop_lifecycle_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wrsl_pkg::*;

	localparam int IDLE_LIMIT     = 2000;
	localparam int NUM_PHASES     = 4;
	localparam int RAND_PER_PHASE = 160;

	typedef struct packed {
		logic [31:0] boot;
		logic [31:0] run;
		logic [31:0] gen;
	} run_key_t;

	// One row of the directed sequence; pinned rows carry a hand-typed status and phase.
	typedef struct {
		item_t      it;
		logic       pinned;
		status_t    pin_status;
		logic [1:0] pin_phase;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic s_tvalid, s_tready;
	// boot_key, run_key, generation_key, stop_tag, resources_freed, gate_open, zero fill
	logic [STREAM_IN_BYTES*8-1:0] s_tdata;
	// func
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// phase_now, bound_boot, bound_run, bound_generation, latched_stop, mutation_allowed,
	// new_work_allowed, binds_seen, stops_latched, acks_built, rejects_seen, zero fill
	logic [STREAM_OUT_BYTES*8-1:0] m_tdata;
	// status
	logic [2:0] m_tuser;

	// Predicted lifecycle state.
	logic [1:0]  lc_phase;
	logic [31:0] lc_boot, lc_run, lc_gen, lc_stop;
	logic [31:0] lc_binds, lc_stops, lc_acks, lc_rejects;
	logic        lc_kind;

	result_t  expected_snapshots[$];
	dir_row_t dir_rows[$];
	run_key_t key_pool[4];
	logic [31:0] tag_pool[3];
	int fails = 0;
	int words_sent = 0;
	int results_checked = 0;
	int idle_cycles = 0;
	int rx_stall = 0;
	int status_hits[6];
	logic calm = 1'b0;

	worker_run_stop_lifecycle #(
		.KEY_WIDTH(32)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// Gap length: mostly none, often short, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] sat_bump(logic [31:0] c);
		return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
	endfunction

	// Applies one word to the predicted state and returns the result word it should produce.
	function automatic result_t lifecycle_step(item_t it);
		result_t res;
		status_t st;
		logic    key_eq;
		st = ST_OK;
		key_eq = (it.boot_key == lc_boot) && (it.run_key == lc_run) &&
			(it.generation_key == lc_gen);
		case (it.func)
			FN_BIND: begin
				if (lc_phase == PHC_BOUND) begin
					if (!key_eq) begin
						lc_rejects = sat_bump(lc_rejects);
						st = ST_INVALID;
					end
				end else if (lc_phase == PHC_PENDING) begin
					lc_rejects = sat_bump(lc_rejects);
					st = ST_INVALID;
				end else if (lc_phase == PHC_QUIESCED && key_eq) begin
					lc_rejects = sat_bump(lc_rejects);
					st = ST_STALE;
				end else begin
					lc_boot = it.boot_key;
					lc_run = it.run_key;
					lc_gen = it.generation_key;
					lc_stop = '0;
					lc_phase = PHC_BOUND;
					lc_binds = sat_bump(lc_binds);
				end
			end
			FN_STOP: begin
				if (lc_phase == PHC_UNBOUND) begin
					lc_rejects = sat_bump(lc_rejects);
					st = ST_INVALID;
				end else if (!key_eq) begin
					lc_rejects = sat_bump(lc_rejects);
					st = ST_STALE;
				end else if (lc_phase == PHC_QUIESCED) begin
					if (lc_stop == it.stop_tag) begin
						st = ST_ACKED;
					end else begin
						lc_rejects = sat_bump(lc_rejects);
						st = ST_INVALID;
					end
				end else if (lc_phase == PHC_PENDING) begin
					if (lc_stop != it.stop_tag) begin
						lc_rejects = sat_bump(lc_rejects);
						st = ST_CONFLICT;
					end
				end else begin
					lc_stop = it.stop_tag;
					lc_phase = PHC_PENDING;
					lc_stops = sat_bump(lc_stops);
				end
			end
			FN_ACK: begin
				if (lc_phase == PHC_QUIESCED) begin
					st = ST_ACKED;
				end else if (lc_phase != PHC_PENDING) begin
					lc_rejects = sat_bump(lc_rejects);
					st = ST_INVALID;
				end else if (!it.resources_freed) begin
					st = ST_NOT_READY;
				end else begin
					lc_phase = PHC_QUIESCED;
					lc_acks = sat_bump(lc_acks);
				end
			end
			default: ;
		endcase
		status_hits[st]++;
		res.status = st;
		res.phase_now = lc_phase;
		res.bound_boot = lc_boot;
		res.bound_run = lc_run;
		res.bound_generation = lc_gen;
		res.latched_stop = lc_stop;
		res.mutation_allowed = (lc_phase == PHC_BOUND) || (lc_phase == PHC_PENDING);
		res.new_work_allowed = (lc_phase == PHC_BOUND) && it.gate_open;
		res.binds_seen = lc_binds;
		res.stops_latched = lc_stops;
		res.acks_built = lc_acks;
		res.rejects_seen = lc_rejects;
		return res;
	endfunction

	// Random word, biased toward the bound key and the latched stop id so that
	// bind, stop and ack sequences walk through every phase.
	function automatic item_t random_word();
		item_t    it;
		run_key_t k;
		int       r;
		r = $urandom_range(0, 99);
		if (r < 25) it.func = FN_BIND;
		else if (r < 55) it.func = FN_STOP;
		else if (r < 85) it.func = FN_ACK;
		else it.func = FN_QUERY;
		k = {lc_boot, lc_run, lc_gen};
		r = $urandom_range(0, 99);
		if (it.func == FN_BIND && r < 40) begin
			// Keep the bound key.
		end else if (it.func != FN_BIND && r < 60) begin
			// Keep the bound key.
		end else if (r < 70) begin
			k = k ^ (96'd1 << $urandom_range(0, 95));
		end else if (r < 88) begin
			k = key_pool[2'($urandom_range(0, 3))];
		end else begin
			k = {$urandom, $urandom, $urandom};
		end
		it.boot_key = k.boot;
		it.run_key = k.run;
		it.generation_key = k.gen;
		r = $urandom_range(0, 99);
		if (r < 50) it.stop_tag = lc_stop;
		else if (r < 75) it.stop_tag = tag_pool[2'($urandom_range(0, 2))];
		else it.stop_tag = $urandom;
		it.resources_freed = ($urandom_range(0, 3) != 0);
		it.gate_open = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic dir_row_t mk_row(func_t f, run_key_t k, logic [31:0] tag, int freed,
		int gate, int pin, status_t ps, logic [1:0] pp);
		dir_row_t row;
		row.it.func = f;
		row.it.boot_key = k.boot;
		row.it.run_key = k.run;
		row.it.generation_key = k.gen;
		row.it.stop_tag = tag;
		row.it.resources_freed = freed[0];
		row.it.gate_open = gate[0];
		row.pinned = pin[0];
		row.pin_status = ps;
		row.pin_phase = pp;
		return row;
	endfunction

	function automatic void cmp_field(string name, logic [31:0] exp, logic [31:0] got);
		if (got !== exp) begin
			$error("%s: expected %0h, got %0h", name, exp, got);
			fails++;
		end
	endfunction

	// Sends one word, records its expected result at acceptance, then, unless calm, may idle a while.
	task automatic send_word(item_t it, logic pinned, status_t ps, logic [1:0] pp);
		result_t exp;
		int      gap;
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, it.gate_open, it.resources_freed, it.stop_tag, it.generation_key,
			it.run_key, it.boot_key};
		s_tuser <= it.func;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		exp = lifecycle_step(it);
		if (pinned) begin
			exp.status = ps;
			exp.phase_now = pp;
		end
		expected_snapshots.push_back(exp);
		words_sent++;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_snapshots.size() != 0) @(posedge clk);
	endtask

	// One APB transfer: setup, access until pready, then idle with psel low.
	task automatic apb_xfer(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= 3'(REG_WORKER_KIND * 4);
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		rdata = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_kind();
		logic [31:0] rd;
		apb_xfer(1'b0, 32'd0, rd);
		if (rd !== {31'b0, lc_kind}) begin
			$error("worker_kind: expected %0h, got %0h", {31'b0, lc_kind}, rd);
			fails++;
		end
	endtask

	task automatic set_kind(logic k);
		logic [31:0] rd;
		apb_xfer(1'b1, {31'b0, k}, rd);
		lc_kind = k;
		check_kind();
	endtask

	// Receiver side: random stalls unless the run is in a calm stretch.
	always @(posedge clk) begin
		if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else begin
			m_tready <= 1'b1;
			if (!calm) rx_stall <= idle_len();
		end
	end

	// Result checker: a word seen at the falling edge is taken at the next rising edge.
	always @(negedge clk) begin : check_result
		result_t got, exp;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = status_t'(m_tuser);
			got.phase_now = m_tdata[1:0];
			got.bound_boot = m_tdata[33:2];
			got.bound_run = m_tdata[65:34];
			got.bound_generation = m_tdata[97:66];
			got.latched_stop = m_tdata[129:98];
			got.mutation_allowed = m_tdata[130];
			got.new_work_allowed = m_tdata[131];
			got.binds_seen = m_tdata[163:132];
			got.stops_latched = m_tdata[195:164];
			got.acks_built = m_tdata[227:196];
			got.rejects_seen = m_tdata[259:228];
			if (expected_snapshots.size() == 0) begin
				$error("result word with no expected result pending");
				fails++;
			end else begin
				exp = expected_snapshots.pop_front();
				cmp_field("status", 32'(exp.status), 32'(got.status));
				cmp_field("phase_now", 32'(exp.phase_now), 32'(got.phase_now));
				cmp_field("bound_boot", exp.bound_boot, got.bound_boot);
				cmp_field("bound_run", exp.bound_run, got.bound_run);
				cmp_field("bound_generation", exp.bound_generation, got.bound_generation);
				cmp_field("latched_stop", exp.latched_stop, got.latched_stop);
				cmp_field("mutation_allowed", 32'(exp.mutation_allowed),
					32'(got.mutation_allowed));
				cmp_field("new_work_allowed", 32'(exp.new_work_allowed),
					32'(got.new_work_allowed));
				cmp_field("binds_seen", exp.binds_seen, got.binds_seen);
				cmp_field("stops_latched", exp.stops_latched, got.stops_latched);
				cmp_field("acks_built", exp.acks_built, got.acks_built);
				cmp_field("rejects_seen", exp.rejects_seen, got.rejects_seen);
				results_checked++;
			end
		end
	end

	// Watchdog on cycles with no handshake on any port.
	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$error("no handshake for %0d cycles", IDLE_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		run_key_t ka, kb, kc;
		logic [31:0] t_ones, t_zero;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		foreach (status_hits[i]) status_hits[i] = 0;

		// State after reset.
		lc_phase = PHC_UNBOUND;
		{lc_boot, lc_run, lc_gen, lc_stop} = '0;
		{lc_binds, lc_stops, lc_acks, lc_rejects} = '0;
		lc_kind = 1'b0;

		ka = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
		kb = {32'h0000_0000, 32'h1234_5678, 32'h0000_0000};
		kc = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE};
		t_ones = 32'hFFFF_FFFF;
		t_zero = 32'h0;
		key_pool[0] = ka;
		key_pool[1] = kb;
		key_pool[2] = {$urandom, $urandom, $urandom};
		key_pool[3] = {$urandom, $urandom, $urandom};
		tag_pool[0] = t_zero;
		tag_pool[1] = t_ones;
		tag_pool[2] = $urandom;

		// Directed walk through every phase and every rejection.
		dir_rows.push_back(mk_row(FN_QUERY, ka, t_ones, 1, 0, 1, ST_OK, PHC_UNBOUND));
		dir_rows.push_back(mk_row(FN_STOP, ka, t_ones, 1, 1, 1, ST_INVALID, PHC_UNBOUND));
		dir_rows.push_back(mk_row(FN_ACK, ka, t_ones, 1, 1, 1, ST_INVALID, PHC_UNBOUND));
		dir_rows.push_back(mk_row(FN_BIND, ka, t_zero, 0, 1, 0, ST_OK, PHC_UNBOUND));
		dir_rows.push_back(mk_row(FN_BIND, ka, t_zero, 0, 0, 1, ST_OK, PHC_BOUND));
		dir_rows.push_back(mk_row(FN_BIND, kc, t_zero, 0, 1, 1, ST_INVALID, PHC_BOUND));
		dir_rows.push_back(mk_row(FN_ACK, ka, t_zero, 1, 1, 1, ST_INVALID, PHC_BOUND));
		dir_rows.push_back(mk_row(FN_STOP, kc, t_ones, 0, 0, 1, ST_STALE, PHC_BOUND));
		dir_rows.push_back(mk_row(FN_STOP, ka, t_ones, 0, 1, 0, ST_OK, PHC_UNBOUND));
		dir_rows.push_back(mk_row(FN_STOP, ka, t_ones, 0, 1, 1, ST_OK, PHC_PENDING));
		dir_rows.push_back(mk_row(FN_STOP, ka, t_zero, 1, 0, 1, ST_CONFLICT, PHC_PENDING));
		dir_rows.push_back(mk_row(FN_BIND, ka, t_ones, 1, 1, 1, ST_INVALID, PHC_PENDING));
		dir_rows.push_back(mk_row(FN_ACK, ka, t_ones, 0, 1, 1, ST_NOT_READY, PHC_PENDING));
		dir_rows.push_back(mk_row(FN_ACK, kb, t_zero, 1, 0, 0, ST_OK, PHC_UNBOUND));
		dir_rows.push_back(mk_row(FN_ACK, ka, t_ones, 1, 1, 1, ST_ACKED, PHC_QUIESCED));
		dir_rows.push_back(mk_row(FN_STOP, ka, t_ones, 1, 1, 1, ST_ACKED, PHC_QUIESCED));
		dir_rows.push_back(mk_row(FN_STOP, ka, t_zero, 0, 0, 1, ST_INVALID, PHC_QUIESCED));
		dir_rows.push_back(mk_row(FN_STOP, kb, t_ones, 1, 1, 1, ST_STALE, PHC_QUIESCED));
		dir_rows.push_back(mk_row(FN_BIND, ka, t_ones, 1, 1, 1, ST_STALE, PHC_QUIESCED));
		dir_rows.push_back(mk_row(FN_BIND, kb, t_ones, 0, 1, 0, ST_OK, PHC_UNBOUND));
		dir_rows.push_back(mk_row(FN_QUERY, kc, t_ones, 0, 1, 0, ST_OK, PHC_UNBOUND));
		dir_rows.push_back(mk_row(FN_STOP, kb, t_zero, 0, 1, 0, ST_OK, PHC_UNBOUND));
		dir_rows.push_back(mk_row(FN_QUERY, ka, t_ones, 1, 1, 0, ST_OK, PHC_UNBOUND));
		dir_rows.push_back(mk_row(FN_ACK, kb, t_ones, 1, 1, 0, ST_OK, PHC_UNBOUND));
		dir_rows.push_back(mk_row(FN_BIND, kc, t_ones, 1, 0, 0, ST_OK, PHC_UNBOUND));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_kind();
		set_kind(1'b1);
		foreach (dir_rows[i])
			send_word(dir_rows[i].it, dir_rows[i].pinned, dir_rows[i].pin_status,
				dir_rows[i].pin_phase);

		// Random phases, alternating the worker kind; the third runs without idling.
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			set_kind(p[0]);
			calm = (p == 2);
			repeat (RAND_PER_PHASE) send_word(random_word(), 1'b0, ST_OK, PHC_UNBOUND);
		end
		calm = 1'b0;

		drain();
		repeat (8) @(posedge clk);

		$display("Checked %0d result words for %0d input words (%0d directed), worker kind 0 and 1.",
			results_checked, words_sent, dir_rows.size());
		$display("Status mix: ok %0d, invalid %0d, stale %0d, conflict %0d, acked %0d, not ready %0d.",
			status_hits[ST_OK], status_hits[ST_INVALID], status_hits[ST_STALE],
			status_hits[ST_CONFLICT], status_hits[ST_ACKED], status_hits[ST_NOT_READY]);
		if (fails == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
